// ----- rtl/core/spq_pkg.sv -----
package spq_pkg;

  localparam int CAPACITY_DEF      = 16;
  localparam int PRIORITY_BITS_DEF = 8;
  localparam int TAG_BITS_DEF      = 16;
  localparam int STATUS_BITS       = 2;

  localparam logic FUNC_ENQUEUE = 1'b0;
  localparam logic FUNC_DEQUEUE = 1'b1;

  typedef enum logic [STATUS_BITS-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  typedef struct packed {
    logic load;
    logic exec;
  } ctrl_cmd_t;

endpackage

// ----- rtl/core/spq_ctrl.sv -----
module spq_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output spq_pkg::ctrl_cmd_t cmd
);

  spq_pkg::state_t state;
  spq_pkg::state_t state_next;
  logic            out_valid_next;

  always_comb begin
    state_next = state;
    case (state)
      spq_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = spq_pkg::ST_EXEC;
        end
      end
      spq_pkg::ST_EXEC: begin
        if (!out_valid || out_ready) begin
          state_next = spq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = spq_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    case (state)
      spq_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      spq_pkg::ST_EXEC: begin
        cmd.exec = !out_valid || out_ready;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.exec) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= spq_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// ----- rtl/core/spq_datapath.sv -----
module spq_datapath #(
  parameter int CAPACITY      = spq_pkg::CAPACITY_DEF,
  parameter int PRIORITY_BITS = spq_pkg::PRIORITY_BITS_DEF,
  parameter int TAG_BITS      = spq_pkg::TAG_BITS_DEF,
  parameter int COUNT_BITS    = $clog2(CAPACITY + 1)
) (
  input  logic                            clk,
  input  logic                            rst,
  input  spq_pkg::ctrl_cmd_t              cmd,
  input  logic                            func,
  input  logic [PRIORITY_BITS-1:0]        priority_req,
  input  logic [TAG_BITS-1:0]             tag,
  output logic [spq_pkg::STATUS_BITS-1:0] status,
  output logic                            removed_valid,
  output logic [PRIORITY_BITS-1:0]        removed_priority,
  output logic [TAG_BITS-1:0]             removed_tag,
  output logic                            head_valid,
  output logic [PRIORITY_BITS-1:0]        head_priority,
  output logic [TAG_BITS-1:0]             head_tag,
  output logic [COUNT_BITS-1:0]           entry_count
);

  logic                     op_func;
  logic [PRIORITY_BITS-1:0] op_prio;
  logic [TAG_BITS-1:0]      op_tag;

  logic [PRIORITY_BITS-1:0] ent_prio [CAPACITY];
  logic [TAG_BITS-1:0]      ent_tag  [CAPACITY];
  logic [PRIORITY_BITS-1:0] ent_prio_next [CAPACITY];
  logic [TAG_BITS-1:0]      ent_tag_next  [CAPACITY];
  logic [COUNT_BITS-1:0]    count;
  logic [COUNT_BITS-1:0]    count_next;
  logic [CAPACITY-1:0]      stays;
  logic                     is_full;
  logic                     is_empty;
  logic                     do_enq;
  logic                     do_deq;
  spq_pkg::status_t         status_next;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_func <= func;
      op_prio <= priority_req;
      op_tag  <= tag;
    end
  end

  // A slot keeps its entry on an enqueue when it is held and not below the new priority.
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      stays[i] = (COUNT_BITS'(i) < count) && (ent_prio[i] >= op_prio);
    end
  end

  assign is_full  = (count == COUNT_BITS'(CAPACITY));
  assign is_empty = (count == '0);
  assign do_enq   = (op_func == spq_pkg::FUNC_ENQUEUE) && !is_full;
  assign do_deq   = (op_func == spq_pkg::FUNC_DEQUEUE) && !is_empty;

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      ent_prio_next[i] = ent_prio[i];
      ent_tag_next[i]  = ent_tag[i];
    end
    count_next  = count;
    status_next = spq_pkg::STATUS_OK;
    if (op_func == spq_pkg::FUNC_ENQUEUE) begin
      if (is_full) begin
        status_next = spq_pkg::STATUS_FULL;
      end else begin
        count_next = count + COUNT_BITS'(1);
        if (!stays[0]) begin
          ent_prio_next[0] = op_prio;
          ent_tag_next[0]  = op_tag;
        end
        for (int i = 1; i < CAPACITY; i++) begin
          if (!stays[i]) begin
            if (stays[i-1]) begin
              ent_prio_next[i] = op_prio;
              ent_tag_next[i]  = op_tag;
            end else begin
              ent_prio_next[i] = ent_prio[i-1];
              ent_tag_next[i]  = ent_tag[i-1];
            end
          end
        end
      end
    end else begin
      if (is_empty) begin
        status_next = spq_pkg::STATUS_EMPTY;
      end else begin
        count_next = count - COUNT_BITS'(1);
        for (int i = 0; i < CAPACITY - 1; i++) begin
          ent_prio_next[i] = ent_prio[i+1];
          ent_tag_next[i]  = ent_tag[i+1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && (do_enq || do_deq)) begin
      for (int i = 0; i < CAPACITY; i++) begin
        ent_prio[i] <= ent_prio_next[i];
        ent_tag[i]  <= ent_tag_next[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.exec) begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      status           <= status_next;
      removed_valid    <= do_deq;
      removed_priority <= do_deq ? ent_prio[0] : '0;
      removed_tag      <= do_deq ? ent_tag[0] : '0;
      head_valid       <= (count_next != '0);
      head_priority    <= (count_next != '0) ? ent_prio_next[0] : '0;
      head_tag         <= (count_next != '0) ? ent_tag_next[0] : '0;
      entry_count      <= count_next;
    end
  end

endmodule

// ----- rtl/core/sorted_priority_queue_unit.sv -----
// A word accepted in the idle state is held in the input register; the result word is then
// registered in the exec state, which waits while the previous result is still to be taken.
// The unit takes no new word until the current one has passed the input register and the single
// compare-and-shift update of the entry row.
// Reset clears the entry count and the handshake state; slot contents are not cleared.
module sorted_priority_queue_unit #(
  parameter int CAPACITY      = spq_pkg::CAPACITY_DEF,
  parameter int PRIORITY_BITS = spq_pkg::PRIORITY_BITS_DEF,
  parameter int TAG_BITS      = spq_pkg::TAG_BITS_DEF,
  parameter int COUNT_BITS    = $clog2(CAPACITY + 1)
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            func,
  input  logic [PRIORITY_BITS-1:0]        priority_req,
  input  logic [TAG_BITS-1:0]             tag,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [spq_pkg::STATUS_BITS-1:0] status,
  output logic                            removed_valid,
  output logic [PRIORITY_BITS-1:0]        removed_priority,
  output logic [TAG_BITS-1:0]             removed_tag,
  output logic                            head_valid,
  output logic [PRIORITY_BITS-1:0]        head_priority,
  output logic [TAG_BITS-1:0]             head_tag,
  output logic [COUNT_BITS-1:0]           entry_count
);

  spq_pkg::ctrl_cmd_t cmd;

  spq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  spq_datapath #(
    .CAPACITY      (CAPACITY),
    .PRIORITY_BITS (PRIORITY_BITS),
    .TAG_BITS      (TAG_BITS),
    .COUNT_BITS    (COUNT_BITS)
  ) u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .func             (func),
    .priority_req     (priority_req),
    .tag              (tag),
    .status           (status),
    .removed_valid    (removed_valid),
    .removed_priority (removed_priority),
    .removed_tag      (removed_tag),
    .head_valid       (head_valid),
    .head_priority    (head_priority),
    .head_tag         (head_tag),
    .entry_count      (entry_count)
  );

endmodule

// ----- bench/spq_checker.sv -----
`timescale 1ns / 100ps

module spq_checker #(
  parameter int CAPACITY      = spq_pkg::CAPACITY_DEF,
  parameter int PRIORITY_BITS = spq_pkg::PRIORITY_BITS_DEF,
  parameter int TAG_BITS      = spq_pkg::TAG_BITS_DEF,
  parameter int COUNT_BITS    = $clog2(CAPACITY + 1)
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  logic                            func,
  input  logic [PRIORITY_BITS-1:0]        priority_req,
  input  logic [TAG_BITS-1:0]             tag,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  logic [spq_pkg::STATUS_BITS-1:0] status,
  input  logic                            removed_valid,
  input  logic [PRIORITY_BITS-1:0]        removed_priority,
  input  logic [TAG_BITS-1:0]             removed_tag,
  input  logic                            head_valid,
  input  logic [PRIORITY_BITS-1:0]        head_priority,
  input  logic [TAG_BITS-1:0]             head_tag,
  input  logic [COUNT_BITS-1:0]           entry_count,
  output int                              fail_count,
  output int                              pending
);

  typedef struct packed {
    spq_pkg::status_t         status;
    logic                     removed_valid;
    logic [PRIORITY_BITS-1:0] removed_priority;
    logic [TAG_BITS-1:0]      removed_tag;
    logic                     head_valid;
    logic [PRIORITY_BITS-1:0] head_priority;
    logic [TAG_BITS-1:0]      head_tag;
    logic [COUNT_BITS-1:0]    entry_count;
  } queue_result_t;

  logic [PRIORITY_BITS-1:0] slot_priority [CAPACITY];
  logic [TAG_BITS-1:0]      slot_tag [CAPACITY];
  int                       held = 0;
  queue_result_t            expected_results [$];
  int                       errors = 0;

  // Slot 0 is the head; a new entry goes behind every held entry of equal or higher priority.
  function automatic queue_result_t predict_queue_op(input logic f,
                                                     input logic [PRIORITY_BITS-1:0] p,
                                                     input logic [TAG_BITS-1:0] t);
    queue_result_t r;
    int pos;
    r = '0;
    r.status = spq_pkg::STATUS_OK;
    if (f == spq_pkg::FUNC_ENQUEUE) begin
      if (held >= CAPACITY) begin
        r.status = spq_pkg::STATUS_FULL;
      end else begin
        pos = 0;
        while (pos < held && slot_priority[pos] >= p) pos++;
        for (int i = held; i > pos; i--) begin
          slot_priority[i] = slot_priority[i-1];
          slot_tag[i] = slot_tag[i-1];
        end
        slot_priority[pos] = p;
        slot_tag[pos] = t;
        held++;
      end
    end else begin
      if (held == 0) begin
        r.status = spq_pkg::STATUS_EMPTY;
      end else begin
        r.removed_valid = 1'b1;
        r.removed_priority = slot_priority[0];
        r.removed_tag = slot_tag[0];
        for (int i = 1; i < held; i++) begin
          slot_priority[i-1] = slot_priority[i];
          slot_tag[i-1] = slot_tag[i];
        end
        held--;
      end
    end
    if (held > 0) begin
      r.head_valid = 1'b1;
      r.head_priority = slot_priority[0];
      r.head_tag = slot_tag[0];
    end
    r.entry_count = COUNT_BITS'(held);
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    queue_result_t want;
    if (rst) begin
      held = 0;
      expected_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("result word arrived with no expected result waiting");
          errors++;
        end else begin
          want = expected_results.pop_front();
          check_field("status", 32'(want.status), 32'(status));
          check_field("removed_valid", 32'(want.removed_valid), 32'(removed_valid));
          check_field("removed_priority", 32'(want.removed_priority), 32'(removed_priority));
          check_field("removed_tag", 32'(want.removed_tag), 32'(removed_tag));
          check_field("head_valid", 32'(want.head_valid), 32'(head_valid));
          check_field("head_priority", 32'(want.head_priority), 32'(head_priority));
          check_field("head_tag", 32'(want.head_tag), 32'(head_tag));
          check_field("entry_count", 32'(want.entry_count), 32'(entry_count));
        end
      end
      if (in_valid && in_ready) begin
        expected_results.push_back(predict_queue_op(func, priority_req, tag));
      end
    end
    fail_count <= errors;
    pending <= expected_results.size();
  end

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;

  localparam int PW         = spq_pkg::PRIORITY_BITS_DEF;
  localparam int TW         = spq_pkg::TAG_BITS_DEF;
  localparam int CW         = $clog2(spq_pkg::CAPACITY_DEF + 1);
  localparam int IDLE_LIMIT = 5000;
  localparam int RANDOM_WORDS = 1040;

  typedef enum int {
    RX_ALWAYS,
    RX_MOSTLY,
    RX_RARELY,
    RX_PERIODIC
  } rx_mode_t;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            in_valid = 1'b0;
  logic                            in_ready;
  logic                            func = spq_pkg::FUNC_ENQUEUE;
  logic [PW-1:0]                   priority_req = '0;
  logic [TW-1:0]                   tag = '0;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  logic [spq_pkg::STATUS_BITS-1:0] status;
  logic                            removed_valid;
  logic [PW-1:0]                   removed_priority;
  logic [TW-1:0]                   removed_tag;
  logic                            head_valid;
  logic [PW-1:0]                   head_priority;
  logic [TW-1:0]                   head_tag;
  logic [CW-1:0]                   entry_count;
  int                              fail_count;
  int                              pending;
  int                              idle_cycles = 0;
  rx_mode_t                        rx_mode = RX_ALWAYS;
  int                              rx_left = 0;
  int unsigned                     rx_tick = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  sorted_priority_queue_unit dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .func             (func),
    .priority_req     (priority_req),
    .tag              (tag),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .status           (status),
    .removed_valid    (removed_valid),
    .removed_priority (removed_priority),
    .removed_tag      (removed_tag),
    .head_valid       (head_valid),
    .head_priority    (head_priority),
    .head_tag         (head_tag),
    .entry_count      (entry_count)
  );

  spq_checker u_checker (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .func             (func),
    .priority_req     (priority_req),
    .tag              (tag),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .status           (status),
    .removed_valid    (removed_valid),
    .removed_priority (removed_priority),
    .removed_tag      (removed_tag),
    .head_valid       (head_valid),
    .head_priority    (head_priority),
    .head_tag         (head_tag),
    .entry_count      (entry_count),
    .fail_count       (fail_count),
    .pending          (pending)
  );

  // The receiver switches among stall patterns, picking a new one whenever its run counter runs out.
  always @(posedge clk) begin
    rx_tick <= rx_tick + 1;
    if (rx_left == 0) begin
      rx_mode <= rx_mode_t'($urandom_range(RX_ALWAYS, RX_PERIODIC));
      rx_left <= $urandom_range(16, 96);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      RX_ALWAYS: out_ready <= 1'b1;
      RX_MOSTLY: out_ready <= ($urandom_range(0, 3) != 0);
      RX_RARELY: out_ready <= ($urandom_range(0, 3) == 0);
      default: out_ready <= (rx_tick[2:0] != 3'd0);
    endcase
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("** sorted_priority_queue_unit: FAILED **");
      $finish;
    end
  end

  task automatic send_word(input logic f, input logic [PW-1:0] p, input logic [TW-1:0] t);
    in_valid <= 1'b1;
    func <= f;
    priority_req <= p;
    tag <= t;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    int unsigned burst_left;
    int unsigned phase_left;
    int unsigned enqueue_pct;
    logic [PW-1:0] p;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Empty dequeue, extreme fields, ties in arrival order, and draining past empty.
    send_word(spq_pkg::FUNC_DEQUEUE, '1, '1);
    send_word(spq_pkg::FUNC_ENQUEUE, '0, '0);
    send_word(spq_pkg::FUNC_ENQUEUE, '1, '1);
    send_word(spq_pkg::FUNC_ENQUEUE, 8'h80, 16'h1111);
    send_word(spq_pkg::FUNC_ENQUEUE, 8'h80, 16'h2222);
    send_word(spq_pkg::FUNC_ENQUEUE, 8'h7f, 16'h3333);
    send_word(spq_pkg::FUNC_ENQUEUE, 8'h80, 16'h4444);
    send_word(spq_pkg::FUNC_ENQUEUE, '0, 16'h5555);
    send_word(spq_pkg::FUNC_ENQUEUE, 8'h81, 16'haaaa);
    repeat (9) send_word(spq_pkg::FUNC_DEQUEUE, '0, '0);
    send_word(spq_pkg::FUNC_DEQUEUE, 8'h55, 16'haaaa);
    drain_results();

    burst_left = 0;
    phase_left = 0;
    enqueue_pct = 50;
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      // Fill and drain phases push the queue to full and to empty again and again.
      if (phase_left == 0) begin
        phase_left = $urandom_range(10, 40);
        case ($urandom_range(0, 2))
          0: enqueue_pct = 85;
          1: enqueue_pct = 15;
          default: enqueue_pct = 50;
        endcase
      end
      phase_left--;
      case ($urandom_range(0, 3))
        0: p = PW'($urandom_range(0, 3));
        1: p = ($urandom_range(0, 1) != 0) ? '1 : '0;
        2: p = PW'($urandom_range(120, 136));
        default: p = PW'($urandom);
      endcase
      if ($urandom_range(1, 100) <= enqueue_pct) begin
        send_word(spq_pkg::FUNC_ENQUEUE, p, TW'($urandom));
      end else begin
        send_word(spq_pkg::FUNC_DEQUEUE, PW'($urandom), TW'($urandom));
      end
      if (n % 250 == 249) begin
        drain_results();
      end else if (burst_left == 0) begin
        burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 100)
                                                 : $urandom_range(1, 12);
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end else begin
        burst_left--;
      end
    end

    drain_results();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("** sorted_priority_queue_unit: PASSED **");
    end else begin
      $display("** sorted_priority_queue_unit: FAILED **");
    end
    $finish;
  end

endmodule

// ----- sorted_priority_queue_unit.f -----
rtl/core/spq_pkg.sv
rtl/core/spq_ctrl.sv
rtl/core/spq_datapath.sv
rtl/core/sorted_priority_queue_unit.sv
bench/spq_checker.sv
bench/tb_top.sv
